// ===== rtl/nps_pkg.sv =====
`timescale 1ns / 1ps
// Package for the nearest point search block: sizes, register indexes, item codes
// and the point and controller interface types. It depends on nothing else.
package nps_pkg;

    localparam int MAX_POINTS = 1024;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int CNT_W      = IDX_W + 1;
    localparam int COORD_W    = 16;
    localparam int ABS_W      = COORD_W;
    localparam int SQ_W       = 2 * ABS_W;
    localparam int DIST_W     = SQ_W + 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = DIST_W;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_NODE_COUNT  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_SQ_DIST = 1'b1;

    // Item kinds.
    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    // Default bound on the squared distance.
    localparam logic [DIST_W-1:0] MAX_SQ_DIST_RST = DIST_W'(99999);

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
    } nps_point_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic             ld_en;
        logic             capture;
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
    } nps_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic pipe_busy;
    } nps_stat_t;

endpackage

// ===== rtl/nps_datapath.sv =====
`timescale 1ns / 1ps
// Datapath of the nearest point search: point memory, the distance pipeline and
// the best-match registers. Depends on nps_pkg.
module nps_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  nps_pkg::nps_cmd_t             cmd,
    output nps_pkg::nps_stat_t            stat,
    input  logic [nps_pkg::IDX_W-1:0]     entry_index,
    input  nps_pkg::nps_point_t           pos,
    input  logic [nps_pkg::DIST_W-1:0]    max_sq_dist,
    output logic                          found,
    output logic [nps_pkg::IDX_W-1:0]     best_index,
    output logic [nps_pkg::DIST_W-1:0]    best_sq_dist
);
    import nps_pkg::*;

    nps_point_t mem [MAX_POINTS];

    nps_point_t       query_reg;
    nps_point_t       pt_reg;
    logic [IDX_W-1:0] idx1_reg, idx2_reg, idx3_reg, idx4_reg;
    logic [ABS_W-1:0] ax_reg, ay_reg, az_reg;
    logic [SQ_W-1:0]  sx_reg, sy_reg, sz_reg;
    logic [DIST_W-1:0] sum_reg;
    logic v1_reg, v2_reg, v3_reg, v4_reg;

    logic              found_reg;
    logic [IDX_W-1:0]  best_idx_reg;
    logic [DIST_W-1:0] best_dist_reg;

    logic [ABS_W-1:0]  ax_next, ay_next, az_next;
    logic [DIST_W-1:0] sum_next;
    logic              take;

    function automatic logic [ABS_W-1:0] abs_diff(
        input logic signed [COORD_W-1:0] a,
        input logic signed [COORD_W-1:0] b
    );
        logic signed [COORD_W:0] d;
        logic        [COORD_W:0] m;
        begin
            d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
            m = d[COORD_W] ? (~d + 1'b1) : d;
            return m[ABS_W-1:0];
        end
    endfunction

    always_comb
    begin
        ax_next  = abs_diff(pt_reg.x, query_reg.x);
        ay_next  = abs_diff(pt_reg.y, query_reg.y);
        az_next  = abs_diff(pt_reg.z, query_reg.z);
        sum_next = DIST_W'(sx_reg) + DIST_W'(sy_reg) + DIST_W'(sz_reg);
        take     = v4_reg && (sum_reg < max_sq_dist)
                   && (!found_reg || (sum_reg < best_dist_reg));
    end

    // Memory ports and pipeline payload.
    always_ff @(posedge clk)
    begin
        if (cmd.ld_en)
        begin
            mem[entry_index] <= pos;
        end
        pt_reg   <= mem[cmd.rd_addr];
        idx1_reg <= cmd.rd_addr;
        if (cmd.capture)
        begin
            query_reg <= pos;
        end
        ax_reg   <= ax_next;
        ay_reg   <= ay_next;
        az_reg   <= az_next;
        idx2_reg <= idx1_reg;
        sx_reg   <= SQ_W'(ax_reg) * SQ_W'(ax_reg);
        sy_reg   <= SQ_W'(ay_reg) * SQ_W'(ay_reg);
        sz_reg   <= SQ_W'(az_reg) * SQ_W'(az_reg);
        idx3_reg <= idx2_reg;
        sum_reg  <= sum_next;
        idx4_reg <= idx3_reg;
    end

    // Pipeline valid bits and the running best match.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            found_reg     <= 1'b0;
            best_idx_reg  <= '0;
            best_dist_reg <= '0;
        end
        else
        begin
            v1_reg <= cmd.rd_en;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            if (cmd.capture)
            begin
                found_reg     <= 1'b0;
                best_idx_reg  <= '0;
                best_dist_reg <= '0;
            end
            else if (take)
            begin
                found_reg     <= 1'b1;
                best_idx_reg  <= idx4_reg;
                best_dist_reg <= sum_reg;
            end
        end
    end

    assign stat.pipe_busy = v1_reg | v2_reg | v3_reg | v4_reg;
    assign found          = found_reg;
    assign best_index     = best_idx_reg;
    assign best_sq_dist   = best_dist_reg;

endmodule

// ===== rtl/nps_ctrl.sv =====
`timescale 1ns / 1ps
// Controller of the nearest point search: accepts items, walks the scan address
// and waits for the distance pipeline to drain. Depends on nps_pkg.
module nps_ctrl (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic                       kind,
    input  logic [nps_pkg::CNT_W-1:0]  node_count,
    input  nps_pkg::nps_stat_t         stat,
    output nps_pkg::nps_cmd_t          cmd,
    output logic                       busy,
    output logic                       done
);
    import nps_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] n_reg, n_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] n_sat;
    logic             accept;

    always_comb
    begin
        n_sat       = (node_count > CNT_W'(MAX_POINTS)) ? CNT_W'(MAX_POINTS) : node_count;
        accept      = start && (state_reg == ST_IDLE);
        cmd.ld_en   = accept && (kind == KIND_LOAD);
        cmd.capture = accept && (kind == KIND_QUERY);
        cmd.rd_en   = (state_reg == ST_SCAN);
        cmd.rd_addr = cnt_reg[IDX_W-1:0];

        state_next = state_reg;
        cnt_next   = cnt_reg;
        n_next     = n_reg;
        done_next  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.capture)
                begin
                    n_next     = n_sat;
                    cnt_next   = '0;
                    state_next = (n_sat == '0) ? ST_DRAIN : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_next == n_reg)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!stat.pipe_busy)
                begin
                    state_next = ST_IDLE;
                    done_next  = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            n_reg     <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            n_reg     <= n_next;
            done_reg  <= done_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;

endmodule

// ===== rtl/nearest_point_search.sv =====
`timescale 1ns / 1ps
// Top level of the nearest point search: configuration registers, controller and
// datapath. Depends on nps_pkg, nps_ctrl and nps_datapath.
//
// A beat is taken when start is high and busy is low. A load beat (kind = 0)
// writes pos_x, pos_y, pos_z into slot entry_index of the point memory in that
// same cycle and gives no result; busy stays low, so loads can follow one per
// cycle. A query beat (kind = 1) raises busy and scans entries 0 to
// node_count-1 (node_count above the table depth is treated as the depth), one
// entry per cycle through a single read port of the point memory, with a short
// pipeline behind it: registered read, absolute differences, squares, sum, and
// the compare against max_sq_dist and the best so far. The result (found,
// best_index, best_sq_dist) is shown for exactly one cycle with done high; the
// receiver cannot stall it, so it must be caught in that cycle. Busy is already
// low in the done cycle, so the next beat may be taken there. On equal
// distances the lowest index wins; when nothing lies strictly below the bound,
// found, best_index and best_sq_dist are all zero.
// Reading a slot that was never loaded since reset gives an undefined point.
// Registers are written through wr_en, wr_index and wr_data and must only be
// written while the block is idle: index 0 is node_count, index 1 is
// max_sq_dist (reset value 99999; 40000 gives a range limit of 200 units).
module nearest_point_search (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic                                 kind,
    input  logic [nps_pkg::IDX_W-1:0]            entry_index,
    input  logic signed [nps_pkg::COORD_W-1:0]   pos_x,
    input  logic signed [nps_pkg::COORD_W-1:0]   pos_y,
    input  logic signed [nps_pkg::COORD_W-1:0]   pos_z,
    output logic                                 done,
    output logic                                 found,
    output logic [nps_pkg::IDX_W-1:0]            best_index,
    output logic [nps_pkg::DIST_W-1:0]           best_sq_dist,
    input  logic                                 wr_en,
    input  logic [nps_pkg::CFG_IDX_W-1:0]        wr_index,
    input  logic [nps_pkg::CFG_DATA_W-1:0]       wr_data
);
    import nps_pkg::*;

    logic [CNT_W-1:0]  node_count_reg;
    logic [DIST_W-1:0] max_sq_dist_reg;
    nps_cmd_t          cmd;
    nps_stat_t         stat;
    nps_point_t        pos;

    // Configuration registers. Writes are only expected while idle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg  <= '0;
            max_sq_dist_reg <= MAX_SQ_DIST_RST;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_NODE_COUNT:  node_count_reg  <= wr_data[CNT_W-1:0];
                REG_MAX_SQ_DIST: max_sq_dist_reg <= wr_data[DIST_W-1:0];
            endcase
        end
    end

    assign pos.x = pos_x;
    assign pos.y = pos_y;
    assign pos.z = pos_z;

    nps_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .kind       (kind),
        .node_count (node_count_reg),
        .stat       (stat),
        .cmd        (cmd),
        .busy       (busy),
        .done       (done)
    );

    nps_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .entry_index  (entry_index),
        .pos          (pos),
        .max_sq_dist  (max_sq_dist_reg),
        .found        (found),
        .best_index   (best_index),
        .best_sq_dist (best_sq_dist)
    );

endmodule
